>>> rtl/pat_pkg.sv
// Shared widths, types, register indexes and reset values for the point affine transform.
// Used by every module of the block; has no dependencies of its own.
package pat_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 16;
    localparam int FRAC    = 12;
    localparam int AXES    = 3;

    // Product of one coordinate and one gain, the four-term sum, and the sum after rounding.
    localparam int PROD_W  = COORD_W + COEF_W;
    localparam int SUM_W   = PROD_W + 3;
    localparam int SHIFT_W = SUM_W - FRAC;
    localparam int ROW_W   = AXES * COEF_W;
    localparam int CFG_W   = (ROW_W > COORD_W) ? ROW_W : COORD_W;
    localparam int IDX_W   = 3;

    localparam int HALF    = 1 << (FRAC - 1);
    localparam logic [COEF_W-1:0] GAIN_ONE = COEF_W'(1 << FRAC);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [SHIFT_W-1:0] t_shift;
    typedef logic [ROW_W-1:0]          t_row;
    typedef logic [IDX_W-1:0]          t_cfg_idx;

    localparam t_cfg_idx REG_ROW_X = 3'd0;
    localparam t_cfg_idx REG_ROW_Y = 3'd1;
    localparam t_cfg_idx REG_ROW_Z = 3'd2;
    localparam t_cfg_idx REG_OFF_X = 3'd3;
    localparam t_cfg_idx REG_OFF_Y = 3'd4;
    localparam t_cfg_idx REG_OFF_Z = 3'd5;

    localparam t_shift SAT_MAX = {{(SHIFT_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam t_shift SAT_MIN = {{(SHIFT_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

    // Load enables for the two lane stages.
    typedef struct packed {
        logic en_s1;
        logic en_s2;
    } t_pipe_ctl;

endpackage

>>> rtl/pat_cfg_regs.sv
// Configuration register file: three packed gain rows and three translation offsets.
// Depends on pat_pkg.
module pat_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  pat_pkg::t_cfg_idx             i_cfg_index,
    input  logic [pat_pkg::CFG_W-1:0]     i_cfg_data,
    output pat_pkg::t_row                 o_gain   [pat_pkg::AXES],
    output pat_pkg::t_coord               o_offset [pat_pkg::AXES]
);

    pat_pkg::t_row   r_gain   [pat_pkg::AXES];
    pat_pkg::t_coord r_offset [pat_pkg::AXES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < pat_pkg::AXES; a++) begin
                r_gain[a]   <= pat_pkg::t_row'(pat_pkg::ROW_W'(pat_pkg::GAIN_ONE)
                               << (a * pat_pkg::COEF_W));
                r_offset[a] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pat_pkg::REG_ROW_X: r_gain[0]   <= i_cfg_data[pat_pkg::ROW_W-1:0];
                pat_pkg::REG_ROW_Y: r_gain[1]   <= i_cfg_data[pat_pkg::ROW_W-1:0];
                pat_pkg::REG_ROW_Z: r_gain[2]   <= i_cfg_data[pat_pkg::ROW_W-1:0];
                pat_pkg::REG_OFF_X: r_offset[0] <= i_cfg_data[pat_pkg::COORD_W-1:0];
                pat_pkg::REG_OFF_Y: r_offset[1] <= i_cfg_data[pat_pkg::COORD_W-1:0];
                pat_pkg::REG_OFF_Z: r_offset[2] <= i_cfg_data[pat_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_gain   = r_gain;
    assign o_offset = r_offset;

endmodule

>>> rtl/pat_lane.sv
// One output axis: three coordinate-by-gain products, then their sum with offset and rounding.
// Depends on pat_pkg.
module pat_lane (
    input  logic                 i_clk,
    input  pat_pkg::t_pipe_ctl   i_ctl,
    input  pat_pkg::t_coord      i_coord [pat_pkg::AXES],
    input  pat_pkg::t_row        i_gain,
    input  pat_pkg::t_coord      i_offset,
    output pat_pkg::t_shift      o_value
);

    pat_pkg::t_prod r_prod [pat_pkg::AXES];
    pat_pkg::t_sum  r_sum;
    pat_pkg::t_sum  n_sum;
    pat_pkg::t_sum  off_term;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s1) begin
            for (int i = 0; i < pat_pkg::AXES; i++) begin
                r_prod[i] <= i_coord[i] * $signed(i_gain[i*pat_pkg::COEF_W +: pat_pkg::COEF_W]);
            end
        end
    end

    // The offset has as many fraction bits as a coordinate and the products 12 more, so it is moved up by FRAC.
    assign off_term = {{(pat_pkg::SUM_W - pat_pkg::COORD_W - pat_pkg::FRAC){i_offset[
                          pat_pkg::COORD_W-1]}}, i_offset, {pat_pkg::FRAC{1'b0}}};

    always_comb begin
        n_sum = off_term + pat_pkg::SUM_W'(pat_pkg::HALF);
        for (int i = 0; i < pat_pkg::AXES; i++) begin
            n_sum = n_sum + pat_pkg::SUM_W'(r_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s2) begin
            r_sum <= n_sum;
        end
    end

    // Dropping the low bits of a two's complement value is a floor division.
    assign o_value = r_sum[pat_pkg::SUM_W-1:pat_pkg::FRAC];

endmodule

>>> rtl/pat_merge.sv
// Merging stage: saturates each lane's result, combines the clip flags and holds the output.
// Depends on pat_pkg.
module pat_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_valid,
    input  pat_pkg::t_shift      i_value [pat_pkg::AXES],
    output logic                 o_valid,
    output pat_pkg::t_coord      o_coord [pat_pkg::AXES],
    output logic                 o_saturated
);

    logic            r_valid;
    pat_pkg::t_coord r_coord [pat_pkg::AXES];
    logic            r_sat;
    pat_pkg::t_coord n_coord [pat_pkg::AXES];
    logic            n_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int a = 0; a < pat_pkg::AXES; a++) begin
            priority if (i_value[a] > pat_pkg::SAT_MAX) begin
                n_coord[a] = pat_pkg::SAT_MAX[pat_pkg::COORD_W-1:0];
                n_sat      = 1'b1;
            end else if (i_value[a] < pat_pkg::SAT_MIN) begin
                n_coord[a] = pat_pkg::SAT_MIN[pat_pkg::COORD_W-1:0];
                n_sat      = 1'b1;
            end else begin
                n_coord[a] = i_value[a][pat_pkg::COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_coord <= n_coord;
            r_sat   <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_coord     = r_coord;
    assign o_saturated = r_sat;

endmodule

>>> rtl/point_affine_transform.sv
// Pipeline: product, sum and output stages, each registered. Throughput: one point per cycle
// while the output is not stalled; a stage loads whenever the one after it is empty or moving.
// Reset: synchronous, active low; empties the pipeline and loads the identity matrix with
// zero translation.
// Depends on pat_pkg, pat_cfg_regs, pat_lane and pat_merge.
module point_affine_transform (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pat_pkg::t_coord               i_x_in,
    input  pat_pkg::t_coord               i_y_in,
    input  pat_pkg::t_coord               i_z_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pat_pkg::t_coord               o_x_out,
    output pat_pkg::t_coord               o_y_out,
    output pat_pkg::t_coord               o_z_out,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  pat_pkg::t_cfg_idx             i_cfg_index,
    input  logic [pat_pkg::CFG_W-1:0]     i_cfg_data
);

    pat_pkg::t_row      gain     [pat_pkg::AXES];
    pat_pkg::t_coord    offset   [pat_pkg::AXES];
    pat_pkg::t_coord    coord_in [pat_pkg::AXES];
    pat_pkg::t_shift    lane_val [pat_pkg::AXES];
    pat_pkg::t_coord    coord_out[pat_pkg::AXES];
    pat_pkg::t_pipe_ctl ctl;
    logic               en_out;
    logic               r_v1;
    logic               r_v2;

    assign en_out     = !o_out_valid || !i_out_stall;
    assign ctl.en_s2  = !r_v2 || en_out;
    assign ctl.en_s1  = !r_v1 || ctl.en_s2;
    assign o_in_stall = !ctl.en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ctl.en_s1) begin
                r_v1 <= i_in_valid;
            end
            if (ctl.en_s2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign coord_in[0] = i_x_in;
    assign coord_in[1] = i_y_in;
    assign coord_in[2] = i_z_in;

    pat_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gain      (gain),
        .o_offset    (offset)
    );

    for (genvar a = 0; a < pat_pkg::AXES; a++) begin : g_lane
        pat_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_coord  (coord_in),
            .i_gain   (gain[a]),
            .i_offset (offset[a]),
            .o_value  (lane_val[a])
        );
    end

    pat_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (en_out),
        .i_valid     (r_v2),
        .i_value     (lane_val),
        .o_valid     (o_out_valid),
        .o_coord     (coord_out),
        .o_saturated (o_saturated)
    );

    assign o_x_out = coord_out[0];
    assign o_y_out = coord_out[1];
    assign o_z_out = coord_out[2];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_v1 && !r_v2)
        else $error("pipeline not empty after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v1 && r_v2 && o_out_valid && i_out_stall)
        else $error("input stalled while the pipeline has room");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_v1)
        else $error("accepted transfer did not enter the first stage");

    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && en_out |=> o_out_valid)
        else $error("second stage result lost on the way to the output register");

endmodule

>>> bench/point_affine_transform_tb.sv
// Self-checking testbench for point_affine_transform: directed and random points under
// several matrix settings, with random idling on both streams. Depends on pat_pkg and the RTL.
`timescale 1ns / 100ps

module point_affine_transform_tb;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASE_POINTS = 170;

    // Indexes past the last register; writes to them must leave the matrix alone.
    localparam pat_pkg::t_cfg_idx REG_SPARE_LO = 3'd6;
    localparam pat_pkg::t_cfg_idx REG_SPARE_HI = 3'd7;

    localparam pat_pkg::t_coord COORD_MAX = 32'sh7FFF_FFFF;
    localparam pat_pkg::t_coord COORD_MIN = 32'sh8000_0000;

    localparam logic [pat_pkg::COEF_W-1:0] G_MAX      = 16'h7FFF;
    localparam logic [pat_pkg::COEF_W-1:0] G_MIN      = 16'h8000;
    localparam logic [pat_pkg::COEF_W-1:0] G_HALF     = 16'h0800;
    localparam logic [pat_pkg::COEF_W-1:0] G_NEG_HALF = 16'hF800;
    localparam logic [pat_pkg::COEF_W-1:0] G_QUARTER  = 16'h0400;
    localparam logic [pat_pkg::COEF_W-1:0] G_ZERO     = 16'h0000;

    typedef struct packed {
        pat_pkg::t_coord x;
        pat_pkg::t_coord y;
        pat_pkg::t_coord z;
        logic            sat;
    } t_xform;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    pat_pkg::t_coord           i_x_in;
    pat_pkg::t_coord           i_y_in;
    pat_pkg::t_coord           i_z_in;
    logic                      o_out_valid;
    logic                      i_out_stall;
    pat_pkg::t_coord           o_x_out;
    pat_pkg::t_coord           o_y_out;
    pat_pkg::t_coord           o_z_out;
    logic                      o_saturated;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    pat_pkg::t_cfg_idx         i_cfg_index;
    logic [pat_pkg::CFG_W-1:0] i_cfg_data;

    // Matrix as the block should hold it.
    pat_pkg::t_row   row_gains [pat_pkg::AXES];
    pat_pkg::t_coord offset_q [pat_pkg::AXES];

    t_xform pending_points [$];
    t_xform oldest;

    bit in_gaps;
    bit out_stalls;
    int mismatches;
    int points_sent;
    int regs_written;
    int results_checked;
    int cycles;

    point_affine_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_z_in      (i_z_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_z_out     (o_z_out),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, pending_points.size());
            $display("point_affine_transform test failed");
            $finish;
        end
    end

    // Each axis: three products plus the offset, rounded half up, then clipped to 32 bits.
    function automatic t_xform transform_point(input pat_pkg::t_coord x,
                                               input pat_pkg::t_coord y,
                                               input pat_pkg::t_coord z);
        t_xform r;
        longint coord [pat_pkg::AXES];
        longint acc;
        longint hi_bound;
        longint lo_bound;
        logic signed [pat_pkg::COEF_W-1:0] gain;
        pat_pkg::t_coord axis_val [pat_pkg::AXES];
        coord[0] = x;
        coord[1] = y;
        coord[2] = z;
        hi_bound = (longint'(1) <<< (pat_pkg::COORD_W - 1)) - 1;
        lo_bound = -hi_bound - 1;
        r.sat = 1'b0;
        for (int a = 0; a < pat_pkg::AXES; a++) begin
            acc = (longint'(offset_q[a]) <<< pat_pkg::FRAC)
                  + (longint'(1) <<< (pat_pkg::FRAC - 1));
            for (int c = 0; c < pat_pkg::AXES; c++) begin
                gain = row_gains[a][c*pat_pkg::COEF_W +: pat_pkg::COEF_W];
                acc += coord[c] * longint'(gain);
            end
            acc = acc >>> pat_pkg::FRAC;
            if (acc > hi_bound) begin
                acc = hi_bound;
                r.sat = 1'b1;
            end else if (acc < lo_bound) begin
                acc = lo_bound;
                r.sat = 1'b1;
            end
            axis_val[a] = acc[pat_pkg::COORD_W-1:0];
        end
        r.x = axis_val[0];
        r.y = axis_val[1];
        r.z = axis_val[2];
        return r;
    endfunction

    function automatic pat_pkg::t_row pack_row(input logic [pat_pkg::COEF_W-1:0] kx,
                                               input logic [pat_pkg::COEF_W-1:0] ky,
                                               input logic [pat_pkg::COEF_W-1:0] kz);
        return {kz, ky, kx};
    endfunction

    function automatic logic [pat_pkg::COEF_W-1:0] random_gain();
        logic [pat_pkg::COEF_W-1:0] g;
        g = pat_pkg::COEF_W'($urandom);
        case ($urandom_range(0, 5))
            0, 1: ;
            2: g = pat_pkg::COEF_W'($urandom_range(0, 16384) - 8192);
            3: g = pat_pkg::GAIN_ONE;
            4: g = $urandom_range(0, 1) ? G_MAX : G_MIN;
            default: g = pat_pkg::COEF_W'($urandom_range(0, 256) - 128);
        endcase
        return g;
    endfunction

    function automatic pat_pkg::t_row random_row();
        return pack_row(random_gain(), random_gain(), random_gain());
    endfunction

    // Mix of full-range, mid-range and small values so both clipped and in-range sums occur.
    function automatic pat_pkg::t_coord random_coord();
        pat_pkg::t_coord c;
        c = $urandom;
        case ($urandom_range(0, 5))
            0: ;
            1, 2: c = c >>> $urandom_range(4, 20);
            3: c = c >>> $urandom_range(1, 3);
            4: c = c >>> $urandom_range(21, 30);
            default: begin
                case ($urandom_range(0, 3))
                    0: c = COORD_MAX;
                    1: c = COORD_MIN;
                    2: c = '0;
                    default: c = '1;
                endcase
            end
        endcase
        return c;
    endfunction

    // Offset registers ignore the bits above the coordinate width, so fill them with noise.
    function automatic logic [pat_pkg::CFG_W-1:0] offset_word(input pat_pkg::t_coord off);
        logic [pat_pkg::CFG_W-1:0] d;
        d = pat_pkg::CFG_W'({$urandom, $urandom});
        d[pat_pkg::COORD_W-1:0] = off;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 40)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_point(input pat_pkg::t_coord x, input pat_pkg::t_coord y,
                              input pat_pkg::t_coord z);
        if (in_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_x_in <= x;
        i_y_in <= y;
        i_z_in <= z;
        do @(posedge i_clk); while (o_in_stall);
        pending_points.push_back(transform_point(x, y, z));
        points_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input pat_pkg::t_cfg_idx idx,
                             input logic [pat_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= pat_pkg::REG_ROW_Z)
            row_gains[2'(idx)] = data[pat_pkg::ROW_W-1:0];
        else if (idx <= pat_pkg::REG_OFF_Z)
            offset_q[2'(idx - pat_pkg::REG_OFF_X)] = data[pat_pkg::COORD_W-1:0];
        regs_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop sending and let the pipeline empty before touching the matrix.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_matrix(input pat_pkg::t_row rx, input pat_pkg::t_row ry,
                              input pat_pkg::t_row rz, input pat_pkg::t_coord ox,
                              input pat_pkg::t_coord oy, input pat_pkg::t_coord oz);
        settle();
        write_reg(pat_pkg::REG_ROW_X, rx);
        write_reg(pat_pkg::REG_ROW_Y, ry);
        write_reg(pat_pkg::REG_ROW_Z, rz);
        write_reg(pat_pkg::REG_OFF_X, offset_word(ox));
        write_reg(pat_pkg::REG_OFF_Y, offset_word(oy));
        write_reg(pat_pkg::REG_OFF_Z, offset_word(oz));
    endtask

    // The reset matrix is the identity, so every point should come back unchanged.
    task automatic test_reset_identity();
        send_point('0, '0, '0);
        send_point(COORD_MAX, COORD_MIN, '1);
        send_point(COORD_MIN, COORD_MAX, 32'sd1);
        send_point(32'sh0001_8000, -32'sh0002_4000, 32'sh5555_AAAA);
    endtask

    // Rows permuted, offsets at both ends, then writes to the spare indexes which must be ignored.
    task automatic test_register_writes();
        set_matrix(pack_row(G_ZERO, pat_pkg::GAIN_ONE, G_ZERO),
                   pack_row(G_ZERO, G_ZERO, pat_pkg::GAIN_ONE),
                   pack_row(pat_pkg::GAIN_ONE, G_ZERO, G_ZERO),
                   COORD_MAX, COORD_MIN, 32'sh0000_8000);
        send_point(-32'sh0000_0001, 32'sh1234_5678, -32'sh0765_4321);
        settle();
        write_reg(REG_SPARE_LO, pat_pkg::CFG_W'({$urandom, $urandom}));
        write_reg(REG_SPARE_HI, pat_pkg::CFG_W'({$urandom, $urandom}));
        send_point(32'sh0003_0000, -32'sh0003_0000, 32'sh0000_0001);
        send_point('0, '0, '0);
    endtask

    // Gains of one half, minus one half and one quarter put the odd x and y inputs and the z inputs exactly on a tie.
    task automatic test_rounding_ties();
        set_matrix(pack_row(G_HALF, G_ZERO, G_ZERO), pack_row(G_ZERO, G_NEG_HALF, G_ZERO),
                   pack_row(G_ZERO, G_ZERO, G_QUARTER), '0, '0, '0);
        send_point(32'sd1, 32'sd1, 32'sd2);
        send_point(-32'sd1, -32'sd1, -32'sd2);
        send_point(32'sd3, -32'sd3, 32'sd6);
        send_point(-32'sd3, 32'sd3, -32'sd6);
    endtask

    // Largest gains and offsets drive the x and y axes past both bounds and z past the upper one.
    task automatic test_saturation();
        set_matrix(pack_row(G_MAX, G_MAX, G_MAX), pack_row(G_MIN, G_MIN, G_MIN),
                   pack_row(G_MAX, G_MIN, pat_pkg::GAIN_ONE), COORD_MAX, COORD_MIN, '0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN, '0);
        send_point('0, '0, '0);
        send_point(32'sd1, '0, '0);
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: set_matrix(pack_row(G_MAX, G_MAX, G_MAX), pack_row(G_MAX, G_MAX, G_MAX),
                              pack_row(G_MAX, G_MAX, G_MAX), COORD_MAX, COORD_MAX, COORD_MAX);
                2: set_matrix(pack_row(G_MIN, G_MIN, G_MIN), pack_row(G_MIN, G_MIN, G_MIN),
                              pack_row(G_MIN, G_MIN, G_MIN), COORD_MIN, COORD_MIN, COORD_MIN);
                default: set_matrix(random_row(), random_row(), random_row(),
                                    random_coord(), random_coord(), random_coord());
            endcase
            // The last two phases run with both streams at full rate.
            in_gaps = (phase < 6) && (phase % 3 != 2);
            out_stalls = (phase < 6) && (phase % 3 != 1);
            repeat (PHASE_POINTS) send_point(random_coord(), random_coord(), random_coord());
        end
    endtask

    // Output back-pressure in random bursts.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_stalls && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_points.size() == 0) begin
                report_mismatch("result transfer with no point pending, x_out", o_x_out, 0);
            end else begin
                oldest = pending_points.pop_front();
                results_checked++;
                if (o_x_out !== oldest.x) report_mismatch("x_out", o_x_out, oldest.x);
                if (o_y_out !== oldest.y) report_mismatch("y_out", o_y_out, oldest.y);
                if (o_z_out !== oldest.z) report_mismatch("z_out", o_z_out, oldest.z);
                if (o_saturated !== oldest.sat)
                    report_mismatch("saturated", o_saturated, oldest.sat);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_x_in = '0;
        i_y_in = '0;
        i_z_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pat_pkg::REG_ROW_X;
        i_cfg_data = '0;
        in_gaps = 1'b1;
        out_stalls = 1'b1;
        row_gains[0] = pack_row(pat_pkg::GAIN_ONE, G_ZERO, G_ZERO);
        row_gains[1] = pack_row(G_ZERO, pat_pkg::GAIN_ONE, G_ZERO);
        row_gains[2] = pack_row(G_ZERO, G_ZERO, pat_pkg::GAIN_ONE);
        offset_q[0] = '0;
        offset_q[1] = '0;
        offset_q[2] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_identity();
        test_register_writes();
        test_rounding_ties();
        test_saturation();
        test_random_stream();

        settle();
        repeat (8) @(negedge i_clk);
        $display("Sent %0d points through %0d register writes; %0d results checked.",
                 points_sent, regs_written, results_checked);
        $display("Settings covered identity, permutation, ties, clipping and random matrices; "
                 , "%0d mismatches.", mismatches);
        if (mismatches == 0 && pending_points.size() == 0)
            $display("point_affine_transform test passed");
        else
            $display("point_affine_transform test failed");
        $finish;
    end

endmodule
